### rtl/core/gf2_polynomial_multiply_divide_assert.svh
// Assertion macros shared by the GF(2) polynomial unit.
`ifndef GF2_POLYNOMIAL_MULTIPLY_DIVIDE_ASSERT_SVH
`define GF2_POLYNOMIAL_MULTIPLY_DIVIDE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define GF2PMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay between the two sides.
`define GF2PMD_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### rtl/core/gf2pmd_pkg.sv
// Shared constants and types of the GF(2) polynomial multiply and divide unit.
package gf2pmd_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned POLY_BITS_DEF = 64;
  // Coefficient steps done in one pipeline stage.
  localparam int unsigned STEPS_PER_STAGE = 8;

  localparam logic OP_CLMUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic valid;
    logic op;
    logic dz;
  } ctrl_t;

endpackage

### rtl/core/gf2pmd_stage.sv
// One pipeline stage of the unit: a group of multiply or long-division steps.
module gf2pmd_stage #(
  parameter int unsigned POLY_BITS = gf2pmd_pkg::POLY_BITS_DEF,
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gf2pmd_pkg::ctrl_t            ctrl_i,
  input  logic [POLY_BITS-1:0]         a_i,
  input  logic [POLY_BITS-1:0]         b_i,
  input  logic [$clog2(POLY_BITS)-1:0] db_i,
  input  logic [2*POLY_BITS-1:0]       acc_i,
  output gf2pmd_pkg::ctrl_t            ctrl_o,
  output logic [POLY_BITS-1:0]         a_o,
  output logic [POLY_BITS-1:0]         b_o,
  output logic [$clog2(POLY_BITS)-1:0] db_o,
  output logic [2*POLY_BITS-1:0]       acc_o
);

  localparam int unsigned DEG_W = $clog2(POLY_BITS);
  localparam int STEPS = int'(gf2pmd_pkg::STEPS_PER_STAGE);

  gf2pmd_pkg::ctrl_t            ctrl_q;
  logic [POLY_BITS-1:0]         a_q;
  logic [POLY_BITS-1:0]         b_q;
  logic [DEG_W-1:0]             db_q;
  logic [2*POLY_BITS-1:0]       acc_d;
  logic [2*POLY_BITS-1:0]       acc_q;

  // Multiply walks the coefficients of a upward and adds shifted copies of b.
  // Divide walks the remainder downward; b arrives aligned to the top bit, so
  // the subtraction at position p is b shifted right by the distance from the
  // top. Quotient bits are collected in the upper half, aligned the same way.
  always_comb begin
    int idx;
    int pos;
    acc_d = acc_i;
    for (int k = 0; k < STEPS; k++) begin
      idx = int'(STAGE_IDX) * STEPS + k;
      pos = int'(POLY_BITS) - 1 - idx;
      if (idx < int'(POLY_BITS)) begin
        if (ctrl_i.op == gf2pmd_pkg::OP_CLMUL) begin
          if (a_i[idx]) begin
            acc_d = acc_d ^ ({{POLY_BITS{1'b0}}, b_i} << idx);
          end
        end else begin
          if ((DEG_W'(pos) >= db_i) && acc_d[pos]) begin
            acc_d[POLY_BITS-1:0] = acc_d[POLY_BITS-1:0] ^ (b_i >> idx);
            acc_d[POLY_BITS+pos] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_i;
    b_q   <= b_i;
    db_q  <= db_i;
    acc_q <= acc_d;
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign db_o   = db_q;
  assign acc_o  = acc_q;

endmodule

### rtl/core/gf2_polynomial_multiply_divide.sv
// Top level of the pipelined GF(2) polynomial multiply and divide unit.
// The unit takes one operation per clock cycle and never raises busy_o. Every
// item gives exactly one result on valid_o after its transfer passes through
// a first register for the operands and the divisor degree, a second that
// aligns the divisor, one stage for each group of eight coefficient steps of
// the multiply or the long division, and an output register that also shifts
// the quotient into place. Results appear for one cycle only and must be taken
// then. A divide by a zero polynomial sets divide_by_zero_o with both result
// words zero.
module gf2_polynomial_multiply_divide #(
  parameter int unsigned POLY_BITS = gf2pmd_pkg::POLY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             operation_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0]   operand_a_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0]   operand_b_i,
  output logic                             valid_o,
  output logic [gf2pmd_pkg::FIELD_W-1:0]   result_low_o,
  output logic [gf2pmd_pkg::FIELD_W-1:0]   result_high_o,
  output logic                             divide_by_zero_o
);

  `include "gf2_polynomial_multiply_divide_assert.svh"

  localparam int unsigned FW = gf2pmd_pkg::FIELD_W;
  localparam int unsigned DEG_W = $clog2(POLY_BITS);
  localparam int unsigned NUM_STAGES =
    (POLY_BITS + gf2pmd_pkg::STEPS_PER_STAGE - 1) / gf2pmd_pkg::STEPS_PER_STAGE;
  localparam int unsigned LATENCY = NUM_STAGES + 3;

  // First register stage: masked operands and divisor degree.
  gf2pmd_pkg::ctrl_t      p1_ctrl_d, p1_ctrl_q;
  logic [POLY_BITS-1:0]   a_in;
  logic [POLY_BITS-1:0]   b_in;
  logic [POLY_BITS-1:0]   p1_a_q;
  logic [POLY_BITS-1:0]   p1_b_q;
  logic [DEG_W-1:0]       p1_db_d, p1_db_q;

  // Second register stage: divisor aligned to the top and accumulator seeded.
  gf2pmd_pkg::ctrl_t      st_ctrl [NUM_STAGES+1];
  logic [POLY_BITS-1:0]   st_a    [NUM_STAGES+1];
  logic [POLY_BITS-1:0]   st_b    [NUM_STAGES+1];
  logic [DEG_W-1:0]       st_db   [NUM_STAGES+1];
  logic [2*POLY_BITS-1:0] st_acc  [NUM_STAGES+1];
  gf2pmd_pkg::ctrl_t      p2_ctrl_q;
  logic [POLY_BITS-1:0]   p2_a_q;
  logic [POLY_BITS-1:0]   p2_b_d, p2_b_q;
  logic [DEG_W-1:0]       p2_db_q;
  logic [2*POLY_BITS-1:0] p2_acc_d, p2_acc_q;

  // Output register.
  logic                   out_valid_q;
  logic [POLY_BITS-1:0]   out_low_d, out_low_q;
  logic [POLY_BITS-1:0]   out_high_d, out_high_q;
  logic                   out_dz_q;

  gf2pmd_pkg::ctrl_t      last_ctrl;
  logic [2*POLY_BITS-1:0] last_acc;
  logic [DEG_W-1:0]       last_db;

  assign busy_o = 1'b0;

  assign a_in = operand_a_i[POLY_BITS-1:0];
  assign b_in = operand_b_i[POLY_BITS-1:0];

  always_comb begin
    p1_ctrl_d.valid = start_i;
    p1_ctrl_d.op    = operation_i;
    p1_ctrl_d.dz    = (operation_i == gf2pmd_pkg::OP_DIV) && (b_in == '0);
    p1_db_d         = '0;
    for (int k = 0; k < int'(POLY_BITS); k++) begin
      if (b_in[k]) begin
        p1_db_d = DEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_ctrl_q <= '0;
      p2_ctrl_q <= '0;
    end else begin
      p1_ctrl_q <= p1_ctrl_d;
      p2_ctrl_q <= p1_ctrl_q;
    end
  end

  always_comb begin
    if (p1_ctrl_q.op == gf2pmd_pkg::OP_DIV) begin
      p2_b_d   = p1_b_q << (DEG_W'(POLY_BITS - 1) - p1_db_q);
      p2_acc_d = {{POLY_BITS{1'b0}}, p1_a_q};
    end else begin
      p2_b_d   = p1_b_q;
      p2_acc_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_a_q   <= a_in;
    p1_b_q   <= b_in;
    p1_db_q  <= p1_db_d;
    p2_a_q   <= p1_a_q;
    p2_b_q   <= p2_b_d;
    p2_db_q  <= p1_db_q;
    p2_acc_q <= p2_acc_d;
  end

  assign st_ctrl[0] = p2_ctrl_q;
  assign st_a[0]    = p2_a_q;
  assign st_b[0]    = p2_b_q;
  assign st_db[0]   = p2_db_q;
  assign st_acc[0]  = p2_acc_q;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    gf2pmd_stage #(
      .POLY_BITS (POLY_BITS),
      .STAGE_IDX (s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (st_ctrl[s]),
      .a_i    (st_a[s]),
      .b_i    (st_b[s]),
      .db_i   (st_db[s]),
      .acc_i  (st_acc[s]),
      .ctrl_o (st_ctrl[s+1]),
      .a_o    (st_a[s+1]),
      .b_o    (st_b[s+1]),
      .db_o   (st_db[s+1]),
      .acc_o  (st_acc[s+1])
    );
  end

  assign last_ctrl = st_ctrl[NUM_STAGES];
  assign last_acc  = st_acc[NUM_STAGES];
  assign last_db   = st_db[NUM_STAGES];

  // The quotient was gathered aligned to the top bit; shift it down by the
  // divisor degree.
  always_comb begin
    if (last_ctrl.dz) begin
      out_low_d  = '0;
      out_high_d = '0;
    end else if (last_ctrl.op == gf2pmd_pkg::OP_DIV) begin
      out_low_d  = last_acc[2*POLY_BITS-1:POLY_BITS] >> last_db;
      out_high_d = last_acc[POLY_BITS-1:0];
    end else begin
      out_low_d  = last_acc[POLY_BITS-1:0];
      out_high_d = last_acc[2*POLY_BITS-1:POLY_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= last_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_low_q  <= out_low_d;
    out_high_q <= out_high_d;
    out_dz_q   <= last_ctrl.dz;
  end

  assign valid_o          = out_valid_q;
  assign result_low_o     = FW'(out_low_q);
  assign result_high_o    = FW'(out_high_q);
  assign divide_by_zero_o = out_valid_q & out_dz_q;

  `GF2PMD_ASSERT_DELAY(a_fixed_latency, start_i && !busy_o, LATENCY, valid_o, "result missing after transfer")
  `GF2PMD_ASSERT_NOW(a_no_stray_result, valid_o, $past(start_i, LATENCY), "result without a transfer")
  `GF2PMD_ASSERT_NOW(a_dz_zero, valid_o && divide_by_zero_o, (result_low_o == '0) && (result_high_o == '0), "zero divisor result not cleared")

endmodule

### tb/gf2_polynomial_multiply_divide_checker.sv
// Checker that predicts and compares every result of the GF(2) polynomial unit.
`timescale 1ns / 100ps

module gf2_polynomial_multiply_divide_checker #(
  parameter int unsigned POLY_BITS = gf2pmd_pkg::POLY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           operation_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0] operand_a_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0] operand_b_i,
  input  logic                           valid_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0] result_low_i,
  input  logic [gf2pmd_pkg::FIELD_W-1:0] result_high_i,
  input  logic                           divide_by_zero_i,
  output int                             error_count_o,
  output int                             outstanding_o
);

  localparam int unsigned W = gf2pmd_pkg::FIELD_W;

  typedef struct packed {
    logic [W-1:0] low;
    logic [W-1:0] high;
    logic         zero_div;
  } poly_result_t;

  poly_result_t expected_results[$];

  // Carry-less product or long division of two masked polynomials.
  function automatic poly_result_t predict_gf2_result(logic op, logic [W-1:0] a_raw,
                                                      logic [W-1:0] b_raw);
    logic [W-1:0]   coeff_mask;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   rem;
    logic [W-1:0]   quo;
    logic [2*W-1:0] prod;
    int             deg_b;
    poly_result_t   res;
    coeff_mask = (POLY_BITS >= W) ? '1 : ((W'(1) << POLY_BITS) - W'(1));
    a = a_raw & coeff_mask;
    b = b_raw & coeff_mask;
    res = '0;
    if (op == gf2pmd_pkg::OP_CLMUL) begin
      prod = '0;
      for (int i = 0; i < int'(POLY_BITS); i++) begin
        if (a[i]) prod ^= {{W{1'b0}}, b} << i;
      end
      res.low = prod[W-1:0] & coeff_mask;
      res.high = W'(prod >> POLY_BITS) & coeff_mask;
    end else if (b == '0) begin
      res.zero_div = 1'b1;
    end else begin
      deg_b = 0;
      for (int k = 0; k < int'(W); k++) begin
        if (b[k]) deg_b = k;
      end
      rem = a;
      quo = '0;
      for (int i = int'(POLY_BITS) - 1; i >= deg_b; i--) begin
        if (rem[i]) begin
          rem ^= b << (i - deg_b);
          quo[i - deg_b] = 1'b1;
        end
      end
      res.low = quo;
      res.high = rem;
    end
    return res;
  endfunction

  // Both counts start at zero and are written only here.
  always @(posedge clk_i) begin
    poly_result_t exp_res;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        expected_results.push_back(predict_gf2_result(operation_i, operand_a_i, operand_b_i));
      end
      if (valid_i) begin
        if (expected_results.size() == 0) begin
          $error("result_low/result_high: result arrived with no operation outstanding");
          error_count_o++;
        end else begin
          exp_res = expected_results.pop_front();
          if (result_low_i !== exp_res.low) begin
            $error("result_low: expected %h, actual %h", exp_res.low, result_low_i);
            error_count_o++;
          end
          if (result_high_i !== exp_res.high) begin
            $error("result_high: expected %h, actual %h", exp_res.high, result_high_i);
            error_count_o++;
          end
          if (divide_by_zero_i !== exp_res.zero_div) begin
            $error("divide_by_zero: expected %b, actual %b", exp_res.zero_div,
                   divide_by_zero_i);
            error_count_o++;
          end
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

### tb/tb_gf2_polynomial_multiply_divide.sv
// Testbench top: stimulus, watchdog and verdict for the GF(2) polynomial unit.
`timescale 1ns / 100ps

module tb_gf2_polynomial_multiply_divide;

  localparam int unsigned POLY_BITS = gf2pmd_pkg::POLY_BITS_DEF;
  localparam int unsigned W = gf2pmd_pkg::FIELD_W;
  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT = 200;
  localparam int DRAIN_CYCLES = 20;

  logic         clk_i;
  logic         rst_ni;
  logic         start_i;
  logic         busy_o;
  logic         operation_i;
  logic [W-1:0] operand_a_i;
  logic [W-1:0] operand_b_i;
  logic         valid_o;
  logic [W-1:0] result_low_o;
  logic [W-1:0] result_high_o;
  logic         divide_by_zero_o;

  int error_count;
  int outstanding;
  int stall_cycles;
  int clmul_sent;
  int div_sent;
  int zero_div_sent;

  gf2_polynomial_multiply_divide #(
    .POLY_BITS(POLY_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .valid_o         (valid_o),
    .result_low_o    (result_low_o),
    .result_high_o   (result_high_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  gf2_polynomial_multiply_divide_checker #(
    .POLY_BITS(POLY_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .operation_i     (operation_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .valid_i         (valid_o),
    .result_low_i    (result_low_o),
    .result_high_i   (result_high_o),
    .divide_by_zero_i(divide_by_zero_o),
    .error_count_o   (error_count),
    .outstanding_o   (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The run stops if neither an operation nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Presents one operation and holds it until the unit takes it.
  task automatic issue_operation(logic op, logic [W-1:0] a, logic [W-1:0] b);
    @(negedge clk_i);
    start_i <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    if (op == gf2pmd_pkg::OP_CLMUL) begin
      clmul_sent++;
    end else begin
      div_sent++;
      if (b == '0) zero_div_sent++;
    end
  endtask

  // Drops start for the given number of cycles with junk on the operand ports.
  task automatic idle_cycles(int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      operation_i <= 1'($urandom);
      operand_a_i <= {$urandom, $urandom};
      operand_b_i <= {$urandom, $urandom};
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Random polynomial, often trimmed to a random degree or a single term.
  function automatic logic [W-1:0] random_poly();
    logic [W-1:0] v;
    int unsigned  len;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = W'(1) << $urandom_range(0, W - 1);
      1, 2: begin
        len = $urandom_range(1, W);
        v = v >> (W - len);
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         op;
    bit           burst;
    clmul_sent = 0;
    div_sent = 0;
    zero_div_sent = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = gf2pmd_pkg::OP_CLMUL;
    operand_a_i = '0;
    operand_b_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed operations: extreme operands and every corner of both operations.
    issue_operation(gf2pmd_pkg::OP_CLMUL, '0, '0);
    issue_operation(gf2pmd_pkg::OP_CLMUL, '1, '1);
    issue_operation(gf2pmd_pkg::OP_CLMUL, '1, '0);
    issue_operation(gf2pmd_pkg::OP_CLMUL, W'(1), '1);
    issue_operation(gf2pmd_pkg::OP_CLMUL, W'(1) << (W - 1), W'(1) << (W - 1));
    issue_operation(gf2pmd_pkg::OP_CLMUL, {(W/2){2'b10}}, {(W/2){2'b01}});
    issue_operation(gf2pmd_pkg::OP_CLMUL, '1, W'(1) << (W - 1));
    idle_cycles(3);
    issue_operation(gf2pmd_pkg::OP_DIV, {(W/2){2'b10}}, '0);
    issue_operation(gf2pmd_pkg::OP_DIV, '0, '0);
    issue_operation(gf2pmd_pkg::OP_DIV, '1, '0);
    issue_operation(gf2pmd_pkg::OP_DIV, '1, W'(1));
    issue_operation(gf2pmd_pkg::OP_DIV, '1, '1);
    issue_operation(gf2pmd_pkg::OP_DIV, '0, W'(64'h1b));
    issue_operation(gf2pmd_pkg::OP_DIV, W'(1) << (W - 1), W'(3));
    // Dividend below the divisor's degree leaves the quotient at zero.
    issue_operation(gf2pmd_pkg::OP_DIV, W'(5), (W'(1) << 40) | W'(1));
    issue_operation(gf2pmd_pkg::OP_DIV, {(W/2){2'b01}}, W'(1) << (W - 1));
    issue_operation(gf2pmd_pkg::OP_DIV, '1, (W'(1) << (W - 1)) | W'(1));
    issue_operation(gf2pmd_pkg::OP_DIV, W'(1) << (W - 1), W'(1) << (W - 1));
    issue_operation(gf2pmd_pkg::OP_DIV, W'(64'hdead_beef_0bad_f00d), W'(64'h1_0000_001b));
    issue_operation(gf2pmd_pkg::OP_DIV, W'(1), '1);

    // Random operations in blocks that are either back to back or gapped.
    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 200 == 199) begin
        // Let the pipeline empty completely before going on.
        idle_cycles(1);
        while (outstanding != 0) @(negedge clk_i);
      end
      op = $urandom_range(0, 1) ? gf2pmd_pkg::OP_DIV : gf2pmd_pkg::OP_CLMUL;
      a = ($urandom_range(0, 31) == 0) ? '0 : random_poly();
      b = ($urandom_range(0, 15) == 0) ? '0 : random_poly();
      issue_operation(op, a, b);
      idle_cycles(burst ? 0 : $urandom_range(0, 11));
    end

    idle_cycles(1);
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d carry-less multiplies and %0d divides, %0d of them by zero,",
             clmul_sent, div_sent, zero_div_sent);
    $display("with back-to-back bursts, random start gaps and full pipeline drains.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gf2pmd_pkg.sv
rtl/core/gf2pmd_stage.sv
rtl/core/gf2_polynomial_multiply_divide.sv
tb/gf2_polynomial_multiply_divide_checker.sv
tb/tb_gf2_polynomial_multiply_divide.sv
